FILE: hdl/mwr_pkg.sv
// ---------------------------------------------------------------------------
// mwr_pkg
// Shared types, constants and the CRC-16/MODBUS byte update for the
// write-single-register frame builder.
// ---------------------------------------------------------------------------
`default_nettype none

package mwr_pkg;

  typedef enum logic [1:0] {
    MODE_RUN      = 2'd0,
    MODE_STOP     = 2'd1,
    MODE_SET_FREQ = 2'd2
  } mode_t;

  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
  localparam logic [7:0]  REG_HIGH          = 8'h00;
  localparam logic [7:0]  REG_LOW_RUN_STOP  = 8'h00;
  localparam logic [7:0]  REG_LOW_FREQ      = 8'h01;
  localparam logic [15:0] VALUE_RUN         = 16'h0001;
  localparam logic [15:0] VALUE_STOP        = 16'h0000;

  // Byte positions in transmit order
  localparam logic [2:0] BYTE_ADDR     = 3'd0;
  localparam logic [2:0] BYTE_FUNC     = 3'd1;
  localparam logic [2:0] BYTE_REG_HIGH = 3'd2;
  localparam logic [2:0] BYTE_REG_LOW  = 3'd3;
  localparam logic [2:0] BYTE_VAL_HIGH = 3'd4;
  localparam logic [2:0] BYTE_VAL_LOW  = 3'd5;
  localparam logic [2:0] BYTE_CRC_LOW  = 3'd6;
  localparam logic [2:0] BYTE_CRC_HIGH = 3'd7;

  // Variable part of one frame
  typedef struct packed {
    logic [7:0]  addr;
    logic [7:0]  reg_low;
    logic [15:0] value;
  } frame_t;

  // Handoff between command stage and serializer
  typedef struct packed {
    logic   valid;
    frame_t frame;
  } frame_req_t;

  // Fold one byte into the reflected CRC: eight shift/xor steps
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] acc;
    acc = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ CRC_POLY;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/mwr_cmd_stage.sv
// ---------------------------------------------------------------------------
// mwr_cmd_stage
// Input register: decodes a drive command into frame fields, keeps the
// latched slave address and holds one frame until the serializer takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module mwr_cmd_stage
  import mwr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_mode,
  input  wire logic [7:0]         in_slave_address,
  input  wire logic signed [15:0] in_frequency_tenths,
  output frame_req_t              req,
  input  wire logic               take
);

  logic       cmd_valid_r, cmd_valid_nxt;
  frame_t     frame_r, frame_nxt;
  logic [7:0] stored_addr_r, stored_addr_nxt;
  logic       accept;
  logic       is_cmd;
  frame_t     decoded;

  always_comb begin
    is_cmd  = 1'b1;
    decoded = frame_r;
    unique case (in_mode)
      MODE_RUN: begin
        decoded.addr    = in_slave_address;
        decoded.reg_low = REG_LOW_RUN_STOP;
        decoded.value   = VALUE_RUN;
      end
      MODE_STOP: begin
        decoded.addr    = in_slave_address;
        decoded.reg_low = REG_LOW_RUN_STOP;
        decoded.value   = VALUE_STOP;
      end
      MODE_SET_FREQ: begin
        decoded.addr    = stored_addr_r;
        decoded.reg_low = REG_LOW_FREQ;
        decoded.value   = $unsigned(in_frequency_tenths);
      end
      default: begin
        is_cmd = 1'b0;  // unused code: drop the command
      end
    endcase
  end

  always_comb begin
    in_stall        = cmd_valid_r && !take;
    accept          = in_valid && !in_stall;
    cmd_valid_nxt   = cmd_valid_r && !take;
    frame_nxt       = frame_r;
    stored_addr_nxt = stored_addr_r;
    if (accept && is_cmd) begin
      cmd_valid_nxt = 1'b1;
      frame_nxt     = decoded;
      if (in_mode != MODE_SET_FREQ) begin
        stored_addr_nxt = in_slave_address;
      end
    end
    req.valid = cmd_valid_r;
    req.frame = frame_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r   <= 1'b0;
      stored_addr_r <= 8'h00;
    end else begin
      cmd_valid_r   <= cmd_valid_nxt;
      stored_addr_r <= stored_addr_nxt;
    end
    frame_r <= frame_nxt;
  end

endmodule

`default_nettype wire

FILE: hdl/mwr_serializer.sv
// ---------------------------------------------------------------------------
// mwr_serializer
// Emits the eight frame bytes one per transfer through an output register,
// folding each header byte into the running CRC as it is loaded.
// ---------------------------------------------------------------------------
`default_nettype none

module mwr_serializer
  import mwr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire frame_req_t  req,
  output logic             take,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_frame_byte,
  output logic             out_last_byte
);

  logic        active_r, active_nxt;
  logic [2:0]  idx_r, idx_nxt;
  frame_t      frame_r, frame_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt;
  logic        advance;
  logic [7:0]  cur_byte;

  // Byte at the current position of the frame in flight
  always_comb begin
    case (idx_r)
      BYTE_ADDR:     cur_byte = frame_r.addr;
      BYTE_FUNC:     cur_byte = FUNC_WRITE_SINGLE;
      BYTE_REG_HIGH: cur_byte = REG_HIGH;
      BYTE_REG_LOW:  cur_byte = frame_r.reg_low;
      BYTE_VAL_HIGH: cur_byte = frame_r.value[15:8];
      BYTE_VAL_LOW:  cur_byte = frame_r.value[7:0];
      BYTE_CRC_LOW:  cur_byte = crc_r[7:0];
      BYTE_CRC_HIGH: cur_byte = crc_r[15:8];
      default:       cur_byte = crc_r[15:8];
    endcase
  end

  always_comb begin
    advance       = !out_valid_r || !out_stall;
    take          = advance && !active_r && req.valid;
    active_nxt    = active_r;
    idx_nxt       = idx_r;
    frame_nxt     = frame_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;

    if (advance && active_r) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = cur_byte;
      out_last_nxt  = (idx_r == BYTE_CRC_HIGH);
      idx_nxt       = idx_r + 3'd1;
      if (idx_r < BYTE_CRC_LOW) begin
        crc_nxt = crc16_byte(crc_r, cur_byte);
      end
      if (idx_r == BYTE_CRC_HIGH) begin
        active_nxt = 1'b0;
      end
    end else if (take) begin
      // Start a new frame: send the address byte straight away
      active_nxt    = 1'b1;
      frame_nxt     = req.frame;
      out_valid_nxt = 1'b1;
      out_byte_nxt  = req.frame.addr;
      out_last_nxt  = 1'b0;
      idx_nxt       = BYTE_FUNC;
      crc_nxt       = crc16_byte(CRC_INIT, req.frame.addr);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= BYTE_ADDR;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
    frame_r    <= frame_nxt;
    crc_r      <= crc_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_last_byte  = out_last_r;

endmodule

`default_nettype wire

FILE: hdl/modbus_write_register_frame_builder.sv
// ---------------------------------------------------------------------------
// modbus_write_register_frame_builder
// Turns drive commands into Modbus RTU write-single-register frames.
// ---------------------------------------------------------------------------
// Each accepted run, stop or set-frequency command yields eight bytes on the
// out_ channel: address, 0x06, 0x00, register low, value high, value low,
// CRC low, CRC high, with out_last_byte set on the CRC high byte. Mode 3 is
// accepted and dropped. Set frequency uses the address latched by the last
// run or stop (zero after reset). The serializer sends one byte per cycle
// while out_stall is low, and frames follow each other with no gap; one
// further command waits in the input register while a frame is going out,
// and in_stall rises only when that register is full. The CRC is updated
// one byte per cycle unless stalled, as header bytes load the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module modbus_write_register_frame_builder
  import mwr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_mode,
  input  wire logic [7:0]         in_slave_address,
  input  wire logic signed [15:0] in_frequency_tenths,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_frame_byte,
  output logic                    out_last_byte
);

  frame_req_t req;
  logic       take;

  mwr_cmd_stage u_cmd (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_slave_address    (in_slave_address),
    .in_frequency_tenths (in_frequency_tenths),
    .req                 (req),
    .take                (take)
  );

  mwr_serializer u_ser (
    .clk            (clk),
    .rst_n          (rst_n),
    .req            (req),
    .take           (take),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte)
  );

endmodule

`default_nettype wire

FILE: tb/modbus_write_register_frame_builder_tb.sv
// ---------------------------------------------------------------------------
// modbus_write_register_frame_builder_tb
// Drives run, stop and set-frequency commands into the frame builder and
// checks every byte of every frame it sends out. The scoreboard keeps its own
// copy of the latched address and builds each expected frame, CRC included.
// Both channels idle at random, with some stretches that run at full rate.
// ---------------------------------------------------------------------------
`default_nettype none

module modbus_write_register_frame_builder_tb
  import mwr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int FRAME_BYTES = 8;
  localparam int MAX_WAIT = 14;
  localparam int RANDOM_COMMANDS = 105;
  localparam int TAIL_CYCLES = 24;
  localparam int STALL_LIMIT = 1000;

  class frame_scoreboard;
    typedef struct packed {
      logic [7:0] data;
      logic       last;
    } frame_byte_t;

    frame_byte_t expected_bytes[$];
    logic [7:0]  latched_addr;
    int          mismatches;
    int          bytes_checked;
    int          mode_count[4];

    function new();
      latched_addr = 8'h00;
      mismatches = 0;
      bytes_checked = 0;
      foreach (mode_count[i]) mode_count[i] = 0;
    endfunction

    function logic [15:0] modbus_crc(logic [7:0] hdr[6]);
      logic [15:0] r;
      r = CRC_INIT;
      foreach (hdr[i]) begin
        r = r ^ {8'h00, hdr[i]};
        repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
    endfunction

    // Build the frame this command should produce and queue its bytes
    function void note_command(logic [1:0] mode, logic [7:0] addr, logic [15:0] freq);
      logic [7:0]  hdr[6];
      logic [7:0]  reg_lo;
      logic [15:0] value;
      logic [15:0] crc;
      mode_count[mode]++;
      case (mode)
        MODE_RUN: begin
          latched_addr = addr;
          reg_lo = REG_LOW_RUN_STOP;
          value = VALUE_RUN;
        end
        MODE_STOP: begin
          latched_addr = addr;
          reg_lo = REG_LOW_RUN_STOP;
          value = VALUE_STOP;
        end
        MODE_SET_FREQ: begin
          reg_lo = REG_LOW_FREQ;
          value = freq;
        end
        default: begin
          return;
        end
      endcase
      hdr = '{latched_addr, FUNC_WRITE_SINGLE, REG_HIGH, reg_lo, value[15:8], value[7:0]};
      crc = modbus_crc(hdr);
      foreach (hdr[i]) expected_bytes.push_back('{hdr[i], 1'b0});
      expected_bytes.push_back('{crc[7:0], 1'b0});
      expected_bytes.push_back('{crc[15:8], 1'b1});
    endfunction

    function void check_byte(logic [7:0] data, logic last);
      frame_byte_t want;
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected byte %02h last=%b with no frame pending",
                   $realtime, data, last);
        return;
      end
      want = expected_bytes.pop_front();
      if (data !== want.data || last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: byte mismatch: expected %02h last=%b, got %02h last=%b",
                   $realtime, want.data, want.last, data, last);
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function bit failed();
      return mismatches != 0 || expected_bytes.size() != 0;
    endfunction
  endclass

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_mode = MODE_RUN;
  logic [7:0]         in_slave_address = 8'h00;
  logic signed [15:0] in_frequency_tenths = 16'sd0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_frame_byte;
  logic               out_last_byte;

  frame_scoreboard sb = new();
  bit  full_rate = 1'b0;
  int  quiet_cycles = 0;

  modbus_write_register_frame_builder dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_slave_address    (in_slave_address),
    .in_frequency_tenths (in_frequency_tenths),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_frame_byte      (out_frame_byte),
    .out_last_byte       (out_last_byte)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Note commands before checking bytes so a same-edge frame finds its entry
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_command(in_mode, in_slave_address, in_frequency_tenths);
      if (out_valid && !out_stall)
        sb.check_byte(out_frame_byte, out_last_byte);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  // Receiver: stall a random number of cycles before each byte
  initial begin : receiver
    int n;
    @(posedge clk iff rst_n);
    forever begin
      n = full_rate ? 0 : $urandom_range(0, MAX_WAIT);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Returns at the edge where the command transfers
  task automatic send_command(logic [1:0] mode, logic [7:0] addr, logic [15:0] freq);
    int gap;
    gap = full_rate ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_mode             <= mode;
    in_slave_address    <= addr;
    in_frequency_tenths <= freq;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold off the sender for at least one edge, then until every frame is out
  task automatic wait_for_frames_out();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [15:0] pick_frequency();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return {16{$urandom_range(0, 1) == 1}};
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int sent;
    int r;
    logic [1:0] mode;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Set frequency before any run or stop uses address zero
    send_command(MODE_SET_FREQ, 8'hFF, 16'h1234);
    send_command(MODE_RUN, 8'h00, 16'hFFFF);
    send_command(MODE_RUN, 8'hFF, 16'h0000);
    send_command(MODE_SET_FREQ, 8'h00, 16'h7FFF);
    send_command(MODE_SET_FREQ, 8'h5A, 16'h8000);
    send_command(MODE_STOP, 8'hA5, 16'h5555);
    send_command(MODE_SET_FREQ, 8'h3C, 16'h0000);
    send_command(MODE_SET_FREQ, 8'hC3, 16'hFFFF);
    send_command(MODE_SET_FREQ, 8'h01, 16'h0001);
    // Unused mode must leave the latched address alone
    send_command(MODE_UNUSED, 8'hFF, 16'hFFFF);
    send_command(MODE_SET_FREQ, 8'h00, 16'd500);
    send_command(MODE_UNUSED, 8'h00, 16'h0000);
    send_command(MODE_STOP, 8'h00, 16'hAAAA);
    send_command(MODE_SET_FREQ, 8'hFF, 16'hFF9C);
    send_command(MODE_RUN, 8'h11, 16'h8000);
    send_command(MODE_STOP, 8'hEE, 16'h7FFF);
    wait_for_frames_out();

    sent = 0;
    while (sent < RANDOM_COMMANDS) begin
      full_rate = (sent >= 30 && sent < 50) || (sent >= 85 && sent < 92);
      if (sent == 60) wait_for_frames_out();
      r = $urandom_range(0, 9);
      mode = (r == 0) ? MODE_UNUSED : 2'((r - 1) % 3);
      send_command(mode, 8'($urandom), pick_frequency());
      if (mode != MODE_UNUSED) sent++;
    end
    full_rate = 1'b0;

    wait_for_frames_out();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d run, %0d stop, %0d set-frequency and %0d unused-mode commands,",
             sb.mode_count[MODE_RUN], sb.mode_count[MODE_STOP],
             sb.mode_count[MODE_SET_FREQ], sb.mode_count[MODE_UNUSED]);
    $display("%0d frame bytes checked, %0d mismatches, %0d bytes never sent.",
             sb.bytes_checked, sb.mismatches, sb.pending());
    if (!sb.failed()) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
